// File: sv/tfna_pkg.sv
// Shared widths and types for the triangle face normal and area pipeline.
`default_nettype none
package tfna_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned EdgeW    = 25;
  localparam int unsigned ProdW    = 50;
  localparam int unsigned CrossW   = 51;
  localparam int unsigned MagW     = 50;
  localparam int unsigned HalfW    = 25;
  localparam int unsigned SqW      = 100;
  localparam int unsigned SumW     = 102;
  localparam int unsigned RadW     = 104;
  localparam int unsigned RootW    = 52;
  localparam int unsigned RootSteps = RadW / 2;
  localparam int unsigned RemW     = 55;
  localparam int unsigned DivRemW  = 53;
  localparam int unsigned QuotW    = 16;
  localparam int unsigned NormW    = 16;
  localparam int unsigned AreaW    = 49;
  localparam int unsigned InDataW  = 216;
  localparam int unsigned OutDataW = 104;

  localparam logic [QuotW-1:0] NormMax = QuotW'(32767);

  // Cross product magnitudes with their signs, carried alongside the root.
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MagW-1:0]  mag;
  } cross_t;

endpackage
`default_nettype wire

// File: sv/tfna_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tfna_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [tfna_pkg::SumW-1:0]   sum_i,
  input  wire tfna_pkg::cross_t            side_i,
  output logic                             vld_o,
  output logic [tfna_pkg::RootW-1:0]       root_o,
  output tfna_pkg::cross_t                 side_o
);

  localparam int unsigned N = tfna_pkg::RootSteps;

  logic                          vld_q  [N];
  logic [tfna_pkg::RadW-1:0]     rad_q  [N];
  logic [tfna_pkg::RemW-1:0]     rem_q  [N];
  logic [tfna_pkg::RootW-1:0]    root_q [N];
  tfna_pkg::cross_t              side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          vld_p;
    logic [tfna_pkg::RadW-1:0]     rad_p;
    logic [tfna_pkg::RemW-1:0]     rem_p;
    logic [tfna_pkg::RootW-1:0]    root_p;
    tfna_pkg::cross_t              side_p;
    logic [tfna_pkg::RemW-1:0]     rem_sh;
    logic [tfna_pkg::RemW-1:0]     trial;
    logic [tfna_pkg::RemW-1:0]     rem_d;
    logic [tfna_pkg::RootW-1:0]    root_d;

    if (k == 0) begin : g_first
      assign vld_p  = vld_i;
      assign rad_p  = {{(tfna_pkg::RadW - tfna_pkg::SumW){1'b0}}, sum_i};
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {rem_p[tfna_pkg::RemW-3:0], rad_p[tfna_pkg::RadW-1 -: 2]};
      trial  = tfna_pkg::RemW'({root_p, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_p[tfna_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_p[tfna_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_p << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = root_q[N-1];
  assign side_o = side_q[N-1];

endmodule
`default_nettype wire

// File: sv/tfna_div.sv
// Three-lane pipelined divider for the normal components, plus output formatting.
`default_nettype none
module tfna_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              vld_i,
  input  wire logic [tfna_pkg::RootW-1:0]        root_i,
  input  wire tfna_pkg::cross_t                  side_i,
  output logic                                   vld_o,
  output logic [2:0][tfna_pkg::NormW-1:0]        normal_o,
  output logic [tfna_pkg::AreaW-1:0]             area_o,
  output logic                                   deg_o
);

  localparam int unsigned N = tfna_pkg::QuotW;

  logic                                   vld_q [N];
  logic [tfna_pkg::RootW-1:0]             m_q   [N];
  logic [2:0]                             neg_q [N];
  logic [2:0][tfna_pkg::DivRemW-1:0]      r_q   [N];
  logic [2:0][tfna_pkg::QuotW-1:0]        quo_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                                 vld_p;
    logic [tfna_pkg::RootW-1:0]           m_p;
    logic [2:0]                           neg_p;
    logic [2:0][tfna_pkg::DivRemW-1:0]    r_p;
    logic [2:0][tfna_pkg::QuotW-1:0]      quo_p;
    logic [2:0][tfna_pkg::DivRemW-1:0]    r_d;
    logic [2:0][tfna_pkg::QuotW-1:0]      quo_d;

    // The first step takes the integer bit of |c| / M, which is 0 or 1.
    if (k == 0) begin : g_first
      assign vld_p = vld_i;
      assign m_p   = root_i;
      assign neg_p = side_i.neg;
      for (genvar l = 0; l < 3; l++) begin : g_in
        assign r_p[l] = tfna_pkg::DivRemW'(side_i.mag[l]);
      end
      assign quo_p = '0;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign m_p   = m_q[k-1];
      assign neg_p = neg_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_in
        assign r_p[l] = {r_q[k-1][l][tfna_pkg::DivRemW-2:0], 1'b0};
      end
      assign quo_p = quo_q[k-1];
    end

    always_comb begin
      logic [tfna_pkg::DivRemW-1:0] mx;
      mx = tfna_pkg::DivRemW'(m_p);
      for (int l = 0; l < 3; l++) begin
        if (r_p[l] >= mx) begin
          r_d[l]   = r_p[l] - mx;
          quo_d[l] = {quo_p[l][tfna_pkg::QuotW-2:0], 1'b1};
        end else begin
          r_d[l]   = r_p[l];
          quo_d[l] = {quo_p[l][tfna_pkg::QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]   <= m_p;
        neg_q[k] <= neg_p;
        r_q[k]   <= r_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  logic                                  out_vld_q;
  logic [2:0][tfna_pkg::NormW-1:0]       norm_q, norm_d;
  logic [tfna_pkg::AreaW-1:0]            area_q;
  logic                                  deg_q, deg_d;

  always_comb begin
    logic [tfna_pkg::QuotW-1:0] qc;
    deg_d = (m_q[N-1] == '0);
    for (int l = 0; l < 3; l++) begin
      qc = (quo_q[N-1][l] > tfna_pkg::NormMax) ? tfna_pkg::NormMax : quo_q[N-1][l];
      if (deg_d) begin
        norm_d[l] = '0;
      end else if (neg_q[N-1][l]) begin
        norm_d[l] = tfna_pkg::NormW'(-qc);
      end else begin
        norm_d[l] = tfna_pkg::NormW'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= norm_d;
      area_q <= m_q[N-1][tfna_pkg::AreaW:1];
      deg_q  <= deg_d;
    end
  end

  assign vld_o    = out_vld_q;
  assign normal_o = norm_q;
  assign area_o   = area_q;
  assign deg_o    = deg_q;

endmodule
`default_nettype wire

// File: sv/triangle_face_normal_area.sv
// Top level: triangle edges, cross product, magnitude, unit normal and area.
//
//  Channel  Direction  Contents
//  s_axis   in         tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
//  m_axis   out        tdata: normal_x normal_y normal_z area, tuser: degenerate
//
// One triangle per cycle enters while m_axis is not stalled; the pipeline has 6 front stages (edges,
// products, cross, square partials, squares, sum), 52 square-root stages (one root
// bit each) and 16 divider stages plus one output register.
// Reset clears only the valid bits. A stall on m_axis freezes the whole pipeline,
// so s_axis_tready is low exactly while a result waits untaken.
`default_nettype none
module triangle_face_normal_area (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (24 bits each)
  input  wire logic [tfna_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // normal_x, normal_y, normal_z (16 bits each), area (49 bits), zero fill
  output logic [tfna_pkg::OutDataW-1:0]        m_axis_tdata,
  // degenerate
  output logic                                 m_axis_tuser
);

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [tfna_pkg::CoordW-1:0] vt [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vt[i] = s_axis_tdata[i*tfna_pkg::CoordW +: tfna_pkg::CoordW];
    end
  end

  logic [5:0] vld_q;

  // Edges: indices 0..2 are e1, 3..5 are e2.
  logic signed [tfna_pkg::EdgeW-1:0] e_q [6], e_d [6];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_d[i]   = $signed({vt[3+i][tfna_pkg::CoordW-1], vt[3+i]})
               - $signed({vt[i][tfna_pkg::CoordW-1], vt[i]});
      e_d[3+i] = $signed({vt[6+i][tfna_pkg::CoordW-1], vt[6+i]})
               - $signed({vt[i][tfna_pkg::CoordW-1], vt[i]});
    end
  end

  logic signed [tfna_pkg::ProdW-1:0] p_q [6], p_d [6];
  always_comb begin
    p_d[0] = e_q[1] * e_q[5];
    p_d[1] = e_q[2] * e_q[4];
    p_d[2] = e_q[2] * e_q[3];
    p_d[3] = e_q[0] * e_q[5];
    p_d[4] = e_q[0] * e_q[4];
    p_d[5] = e_q[1] * e_q[3];
  end

  tfna_pkg::cross_t cr_d, cr3_q, cr4_q, cr5_q, cr6_q;
  always_comb begin
    logic signed [tfna_pkg::CrossW-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c = $signed({p_q[2*i][tfna_pkg::ProdW-1], p_q[2*i]})
        - $signed({p_q[2*i+1][tfna_pkg::ProdW-1], p_q[2*i+1]});
      cr_d.neg[i] = c[tfna_pkg::CrossW-1];
      cr_d.mag[i] = c[tfna_pkg::CrossW-1] ? tfna_pkg::MagW'(-c) : tfna_pkg::MagW'(c);
    end
  end

  // Squares of 50-bit magnitudes are split into 25-bit halves.
  logic [2:0][tfna_pkg::ProdW-1:0] hh_q, hl_q, ll_q, hh_d, hl_d, ll_d;
  always_comb begin
    logic [tfna_pkg::HalfW-1:0] ah, al;
    for (int i = 0; i < 3; i++) begin
      ah = cr3_q.mag[i][tfna_pkg::MagW-1 -: tfna_pkg::HalfW];
      al = cr3_q.mag[i][tfna_pkg::HalfW-1:0];
      hh_d[i] = tfna_pkg::ProdW'(ah) * tfna_pkg::ProdW'(ah);
      hl_d[i] = tfna_pkg::ProdW'(ah) * tfna_pkg::ProdW'(al);
      ll_d[i] = tfna_pkg::ProdW'(al) * tfna_pkg::ProdW'(al);
    end
  end

  logic [2:0][tfna_pkg::SqW-1:0] sq_q, sq_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (tfna_pkg::SqW'(hh_q[i]) << (2 * tfna_pkg::HalfW))
              + (tfna_pkg::SqW'(hl_q[i]) << (tfna_pkg::HalfW + 1))
              + tfna_pkg::SqW'(ll_q[i]);
    end
  end

  logic [tfna_pkg::SumW-1:0] sum_q, sum_d;
  assign sum_d = tfna_pkg::SumW'(sq_q[0]) + tfna_pkg::SumW'(sq_q[1])
               + tfna_pkg::SumW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q   <= e_d;
      p_q   <= p_d;
      cr3_q <= cr_d;
      hh_q  <= hh_d;
      hl_q  <= hl_d;
      ll_q  <= ll_d;
      cr4_q <= cr3_q;
      sq_q  <= sq_d;
      cr5_q <= cr4_q;
      sum_q <= sum_d;
      cr6_q <= cr5_q;
    end
  end

  logic                        rt_vld;
  logic [tfna_pkg::RootW-1:0]  rt_root;
  tfna_pkg::cross_t            rt_side;

  tfna_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_q[5]),
    .sum_i  (sum_q),
    .side_i (cr6_q),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  logic [2:0][tfna_pkg::NormW-1:0] normal;
  logic [tfna_pkg::AreaW-1:0]      area;
  logic                            deg;

  tfna_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (rt_vld),
    .root_i   (rt_root),
    .side_i   (rt_side),
    .vld_o    (m_axis_tvalid),
    .normal_o (normal),
    .area_o   (area),
    .deg_o    (deg)
  );

  assign m_axis_tdata = {{(tfna_pkg::OutDataW - 3*tfna_pkg::NormW - tfna_pkg::AreaW){1'b0}},
                         area, normal[2], normal[1], normal[0]};
  assign m_axis_tuser = deg;

  // A degenerate triangle has zero normal and zero area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && deg |-> (normal == '0) && (area == '0))
    else $error("degenerate result with nonzero normal or area");

  // Any real triangle has a dominant component well away from zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !deg |-> (normal != '0))
    else $error("nondegenerate result with zero normal");

  // Clamping keeps every component off the most negative code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (normal[0] != 16'h8000) && (normal[1] != 16'h8000)
                   && (normal[2] != 16'h8000))
    else $error("normal component outside the clamped range");

endmodule
`default_nettype wire
